/* src/vt44_pkg.sv */
// ----------------------------------------------------------------------------
// vt44_pkg
// Shared types, widths and helper functions of the 4x4 vertex transform block.
// ----------------------------------------------------------------------------
package vt44_pkg;

    localparam int FRAC_BITS   = 16;  // fraction bits of the fixed point format
    localparam int WORD_BITS   = 32;  // stored matrix element width
    localparam int IO_BITS     = 32;  // width of every value field on the ports
    localparam int QUEUE_DEPTH = 4;

    localparam int WIDE_BITS = (WORD_BITS > IO_BITS) ? WORD_BITS : IO_BITS;
    localparam int OP_BITS   = WIDE_BITS + 1;  // room for a negated element
    localparam int PROD_BITS = 2 * OP_BITS;
    localparam int HALF_BITS = PROD_BITS + 1;
    localparam int SUM_BITS  = PROD_BITS + 2;

    localparam int IN_FIELD_BITS = 2 + 2 + 5 * IO_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 4 * IO_BITS;

    localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] UNIT_VALUE =
        (FRAC_BITS < WORD_BITS - 1) ? WORD_BITS'(64'd1 << FRAC_BITS) : WORD_MAX;

    // action codes on the input tuser
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_XFORM  = 2'd1,
        ACT_INVERT = 2'd2
    } t_action;

    // work kinds carried through the queue
    typedef enum logic [1:0] {
        K_LOAD,
        K_XFORM,
        K_INVERT
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic [1:0]                row;
        logic [1:0]                col;
        logic [3:0][IO_BITS-1:0]   data;  // lane 0 holds the element value on a load
    } t_entry;

    typedef struct packed {
        logic                  flag;
        logic [WORD_BITS-1:0]  value;
    } t_sat;

    // sign extend or truncate a stored word to a port field
    function automatic logic [IO_BITS-1:0] to_io(logic signed [WORD_BITS-1:0] v);
        logic signed [WIDE_BITS-1:0] t;
        t = v;
        return t[IO_BITS-1:0];
    endfunction

    // clamp a port value into the stored word range
    function automatic logic signed [WORD_BITS-1:0] load_sat(logic signed [IO_BITS-1:0] v);
        logic signed [WIDE_BITS-1:0]     t;
        logic [WIDE_BITS-WORD_BITS:0]    hi;
        t  = v;
        hi = t[WIDE_BITS-1:WORD_BITS-1];
        if ((&hi) || !(|hi)) begin
            return t[WORD_BITS-1:0];
        end else begin
            return t[WIDE_BITS-1] ? WORD_MIN : WORD_MAX;
        end
    endfunction

    // arithmetic shift down by the fraction bits, then clamp to a word
    function automatic t_sat shift_sat(logic signed [SUM_BITS-1:0] s);
        logic signed [SUM_BITS-1:0]    sh;
        logic [SUM_BITS-WORD_BITS:0]   hi;
        t_sat                          r;
        sh = s >>> FRAC_BITS;
        hi = sh[SUM_BITS-1:WORD_BITS-1];
        if ((&hi) || !(|hi)) begin
            r.flag  = 1'b0;
            r.value = sh[WORD_BITS-1:0];
        end else begin
            r.flag  = 1'b1;
            r.value = sh[SUM_BITS-1] ? WORD_MIN : WORD_MAX;
        end
        return r;
    endfunction

endpackage

/* src/vt44_front.sv */
// ----------------------------------------------------------------------------
// vt44_front
// Input stage: takes stream transfers, decodes the action into a work kind,
// drops the unused code and pushes the work into the queue.
// ----------------------------------------------------------------------------
module vt44_front
    import vt44_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,
    input  logic [1:0]               i_s_axis_tuser,
    output logic                     o_push,
    output t_entry                   o_entry,
    input  logic                     i_full
);

    logic    r_valid;
    logic    n_valid;
    t_entry  r_entry;
    t_entry  n_entry;
    logic    keep;
    logic    accept;

    assign o_s_axis_tready = !r_valid || !i_full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = r_valid && !i_full;
    assign o_entry         = r_entry;

    always_comb begin
        keep          = 1'b1;
        n_entry.kind  = K_LOAD;
        n_entry.row   = i_s_axis_tdata[1:0];
        n_entry.col   = i_s_axis_tdata[3:2];
        n_entry.data[0] = i_s_axis_tdata[4 +: IO_BITS];
        for (int k = 1; k < 4; k++) begin
            n_entry.data[k] = i_s_axis_tdata[4 + (k + 1) * IO_BITS +: IO_BITS];
        end
        case (t_action'(i_s_axis_tuser))
            ACT_LOAD: begin
                n_entry.kind = K_LOAD;
            end
            ACT_XFORM: begin
                n_entry.kind    = K_XFORM;
                n_entry.data[0] = i_s_axis_tdata[4 + IO_BITS +: IO_BITS];
            end
            ACT_INVERT: begin
                n_entry.kind = K_INVERT;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign n_valid = (r_valid && !o_push) || (accept && keep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

/* src/vt44_queue.sv */
// ----------------------------------------------------------------------------
// vt44_queue
// Short first-in first-out queue between the front and the back, head shown
// without a read delay.
// ----------------------------------------------------------------------------
module vt44_queue
    import vt44_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_entry  o_head
);

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr;
    logic [QPTR_BITS-1:0]  r_rd;
    logic [QCNT_BITS-1:0]  r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [QPTR_BITS-1:0] bump(logic [QPTR_BITS-1:0] p);
        if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
            return '0;
        end else begin
            return p + 1'b1;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= bump(r_wr);
            end
            if (do_pop) begin
                r_rd <= bump(r_rd);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* src/vt44_back.sv */
// ----------------------------------------------------------------------------
// vt44_back
// Execution side: holds the matrix, applies loads, and runs transforms and
// rigid inverses through a multiply / pair add / final add pipeline with an
// output register.
// ----------------------------------------------------------------------------
module vt44_back
    import vt44_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_entry                    i_head,
    output logic                      o_pop,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]  o_m_axis_tdata,
    output logic [0:0]                o_m_axis_tuser
);

    logic signed [WORD_BITS-1:0]  r_mat [16];

    logic                         r_s1_valid;
    t_kind                        r_s1_kind;
    logic signed [PROD_BITS-1:0]  r_prod [4][4];

    logic                         r_s2_valid;
    t_kind                        r_s2_kind;
    logic signed [HALF_BITS-1:0]  r_half [4][2];

    logic                         r_out_valid;
    logic [3:0][IO_BITS-1:0]      r_out;
    logic                         r_ovf;

    logic                         r_inv_busy;

    logic                         en;
    logic                         issue;
    logic                         s2_xform;
    logic                         s2_invert;
    logic signed [OP_BITS-1:0]    op_a [4][4];
    logic signed [OP_BITS-1:0]    op_b [4][4];
    logic signed [OP_BITS-1:0]    tcol [3];
    logic signed [SUM_BITS-1:0]   sum [4];
    t_sat                         sres [4];
    logic                         any_sat;

    // whole pipe moves unless the output register is stuck
    assign en        = !r_out_valid || i_m_axis_tready;
    assign issue     = i_valid && en && !r_inv_busy;
    assign o_pop     = issue;
    assign s2_xform  = r_s2_valid && (r_s2_kind == K_XFORM);
    assign s2_invert = r_s2_valid && (r_s2_kind == K_INVERT);

    // operand selection for the sixteen multipliers
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tcol[k] = OP_BITS'(r_mat[k * 4 + 3]);
        end
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) begin
                op_a[i][k] = '0;
                op_b[i][k] = '0;
                case (i_head.kind)
                    K_XFORM: begin
                        op_a[i][k] = OP_BITS'(r_mat[i * 4 + k]);
                        op_b[i][k] = OP_BITS'($signed(i_head.data[k]));
                    end
                    K_INVERT: begin
                        // new translation: transposed rotation times negated translation
                        if (i < 3 && k < 3) begin
                            op_a[i][k] = OP_BITS'(r_mat[k * 4 + i]);
                            op_b[i][k] = -tcol[k];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        any_sat = 1'b0;
        for (int i = 0; i < 4; i++) begin
            sum[i]  = SUM_BITS'(r_half[i][0]) + SUM_BITS'(r_half[i][1]);
            sres[i] = shift_sat(sum[i]);
            any_sat = any_sat | sres[i].flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_inv_busy  <= 1'b0;
            for (int j = 0; j < 16; j++) begin
                r_mat[j] <= '0;
            end
        end else begin
            if (en) begin
                r_s1_valid  <= issue && (i_head.kind inside {K_XFORM, K_INVERT});
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= s2_xform;
            end
            if (issue && i_head.kind == K_LOAD) begin
                r_mat[{i_head.row, i_head.col}] <= load_sat($signed(i_head.data[0]));
            end
            if (issue && i_head.kind == K_INVERT) begin
                r_inv_busy <= 1'b1;
            end
            // inverse writeback, issue is held off until this lands
            if (en && s2_invert) begin
                r_inv_busy <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_mat[i * 4 + k] <= r_mat[k * 4 + i];
                    end
                    r_mat[i * 4 + 3] <= sres[i].value;
                end
                r_mat[12] <= '0;
                r_mat[13] <= '0;
                r_mat[14] <= '0;
                r_mat[15] <= UNIT_VALUE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind <= i_head.kind;
            r_s2_kind <= r_s1_kind;
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 4; k++) begin
                    r_prod[i][k] <= PROD_BITS'(op_a[i][k]) * PROD_BITS'(op_b[i][k]);
                end
                r_half[i][0] <= HALF_BITS'(r_prod[i][0]) + HALF_BITS'(r_prod[i][1]);
                r_half[i][1] <= HALF_BITS'(r_prod[i][2]) + HALF_BITS'(r_prod[i][3]);
            end
            if (s2_xform) begin
                for (int i = 0; i < 4; i++) begin
                    r_out[i] <= to_io(sres[i].value);
                end
                r_ovf <= any_sat;
            end
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out;
    assign o_m_axis_tuser[0] = r_ovf;

endmodule

/* src/vertex_transform_4x4_top.sv */
// ----------------------------------------------------------------------------
// vertex_transform_4x4_top
// 4x4 fixed point transform matrix: element loads, vector transforms with
// saturation and overflow flag, and in-place rigid inverse.
//
//   channel   | dir | tdata                                   | tuser
//   s_axis    | in  | row, col, elem_value, vec_x..vec_w      | action
//   m_axis    | out | out_x, out_y, out_z, out_w              | overflow
//
// loads and transforms are taken one per cycle unless the output stalls or an
// inverse runs; a transform result passes the input register, queue, multiply,
// pair add, and final add into the output register
// an inverse keeps the next queue head waiting while it runs through
// the shared multiply / add pipe and writes the matrix back
// reset clears the matrix to zero in the same cycle, no clearing pass
// a stalled output freezes the pipe; the queue and input register keep
// taking transfers until full
// ----------------------------------------------------------------------------
module vertex_transform_4x4_top
    import vt44_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // row[1:0], col[3:2], elem_value, vec_x, vec_y, vec_z, vec_w, zero pad
    input  logic [IN_DATA_BITS-1:0]   i_s_axis_tdata,
    // action[1:0]
    input  logic [1:0]                i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // out_x, out_y, out_z, out_w
    output logic [OUT_DATA_BITS-1:0]  o_m_axis_tdata,
    // overflow[0]
    output logic [0:0]                o_m_axis_tuser
);

    logic    push;
    t_entry  push_entry;
    logic    q_full;
    logic    q_valid;
    t_entry  q_head;
    logic    pop;

    vt44_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_push          (push),
        .o_entry         (push_entry),
        .i_full          (q_full)
    );

    vt44_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    vt44_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_head          (q_head),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

/* src/vt44_checker.sv */
// ----------------------------------------------------------------------------
// vt44_checker
// Port level checks of the vertex transform block, bound to the top level.
// ----------------------------------------------------------------------------
module vt44_checker
    import vt44_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    input  logic                      o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]   i_s_axis_tdata,
    input  logic [1:0]                i_s_axis_tuser,
    input  logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    input  logic [OUT_DATA_BITS-1:0]  o_m_axis_tdata,
    input  logic [0:0]                o_m_axis_tuser
);

    localparam logic [IO_BITS-1:0] OUT_MAX = to_io(WORD_MAX);
    localparam logic [IO_BITS-1:0] OUT_MIN = to_io(WORD_MIN);

    logic [IO_BITS-1:0] ox;
    logic [IO_BITS-1:0] oy;
    logic [IO_BITS-1:0] oz;
    logic [IO_BITS-1:0] ow;

    assign ox = o_m_axis_tdata[0 * IO_BITS +: IO_BITS];
    assign oy = o_m_axis_tdata[1 * IO_BITS +: IO_BITS];
    assign oz = o_m_axis_tdata[2 * IO_BITS +: IO_BITS];
    assign ow = o_m_axis_tdata[3 * IO_BITS +: IO_BITS];

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // nothing is left over from before reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // input side is open right after reset
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

    // a flagged result carries at least one clamped component
    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            (ox == OUT_MAX || ox == OUT_MIN || oy == OUT_MAX || oy == OUT_MIN ||
             oz == OUT_MAX || oz == OUT_MIN || ow == OUT_MAX || ow == OUT_MIN))
        else $error("overflow flagged without a clamped component");

endmodule

bind vertex_transform_4x4_top vt44_checker u_checker (.*);

/* tb/vertex_transform_4x4_top_tb.sv */
// ----------------------------------------------------------------------------
// vertex_transform_4x4_top_tb
// Self-checking bench for the 4x4 fixed point vertex transform. Element loads,
// vector transforms, rigid inverses and ignored codes are streamed in. A local
// Q16.16 copy of the matrix predicts every transform result, which is compared
// lane by lane with the output stream. Traffic runs through phases of source
// idling and sink stalling, including one long sink hold-off.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_top_tb;
    import vt44_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_OPS    = 450;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;
    localparam logic [31:0] W_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN        = 32'h8000_0000;
    localparam logic [31:0] W_UNIT       = 32'h0001_0000;
    localparam logic signed [71:0] Q_MAX = 72'sh7FFF_FFFF;
    localparam logic signed [71:0] Q_MIN = -72'sh8000_0000;

    typedef struct packed {
        logic [1:0]              action;
        logic [1:0]              row;
        logic [1:0]              col;
        logic [IO_BITS-1:0]      elem;
        logic [3:0][IO_BITS-1:0] vec;
    } t_vertex_op;

    typedef struct packed {
        logic [3:0][IO_BITS-1:0] lane;
        logic                    ovf;
    } t_xform_result;

    typedef struct packed {
        logic        flag;
        logic [31:0] value;
    } t_sat_word;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_valid = 1'b0;
    logic [IN_DATA_BITS-1:0]  s_data = '0;
    logic [1:0]               s_user = '0;
    logic                     m_ready = 1'b0;
    logic                     s_ready;
    logic                     m_valid;
    logic [OUT_DATA_BITS-1:0] m_data;
    logic [0:0]               m_user;

    t_vertex_op    vertex_op_q[$];
    t_xform_result xform_expect_q[$];
    t_vertex_op    held_op;
    logic signed [31:0] mtx_q16 [16];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  tame_vals = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  cycle_cnt = 0;
    int  err_cnt = 0;
    int  queued_ops = 0;
    int  n_loads = 0, n_xforms = 0, n_inverts = 0, n_ignored = 0;
    int  n_results = 0, n_sat = 0;

    vertex_transform_4x4_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always #5 i_clk = ~i_clk;

    // shift out the fraction bits and clamp to a signed word
    function automatic t_sat_word narrow_q16(input logic signed [71:0] s);
        logic signed [71:0] sh;
        t_sat_word          r;
        sh = s >>> FRAC_BITS;
        if (sh > Q_MAX) begin
            r = {1'b1, W_MAX};
        end else if (sh < Q_MIN) begin
            r = {1'b1, W_MIN};
        end else begin
            r = {1'b0, sh[31:0]};
        end
        return r;
    endfunction

    // matrix update and result prediction for one accepted transfer
    task automatic apply_vertex_op(input t_vertex_op op);
        logic signed [71:0] acc, a, b;
        logic signed [31:0] nm [16];
        t_sat_word          r;
        t_xform_result      res;
        case (op.action)
            ACT_LOAD: begin
                mtx_q16[{op.row, op.col}] = op.elem;
                n_loads++;
            end
            ACT_XFORM: begin
                res.ovf = 1'b0;
                for (int i = 0; i < 4; i++) begin
                    acc = '0;
                    for (int k = 0; k < 4; k++) begin
                        a = 72'(mtx_q16[i*4+k]);
                        b = 72'($signed(op.vec[k]));
                        acc = acc + a * b;
                    end
                    r = narrow_q16(acc);
                    res.lane[i] = r.value;
                    res.ovf |= r.flag;
                end
                xform_expect_q.push_back(res);
                n_xforms++;
            end
            ACT_INVERT: begin
                // transpose rotation, translation = -R^T * t, saturated silently
                for (int i = 0; i < 3; i++) begin
                    acc = '0;
                    for (int k = 0; k < 3; k++) begin
                        nm[i*4+k] = mtx_q16[k*4+i];
                        a = 72'(mtx_q16[k*4+i]);
                        b = 72'(mtx_q16[k*4+3]);
                        acc = acc + a * (-b);
                    end
                    r = narrow_q16(acc);
                    nm[i*4+3] = r.value;
                end
                nm[12] = '0;
                nm[13] = '0;
                nm[14] = '0;
                nm[15] = W_UNIT;
                for (int i = 0; i < 16; i++) mtx_q16[i] = nm[i];
                n_inverts++;
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    function automatic logic [31:0] pick_word(input bit tame);
        logic [31:0] v;
        v = $urandom_range(32'h0008_0000) - 32'h0004_0000;
        if (!tame) begin
            case ($urandom_range(9))
                0:       v = W_MIN;
                1:       v = W_MAX;
                2:       v = '0;
                3, 4, 5: v = $urandom();
                default: ;
            endcase
        end
        return v;
    endfunction

    task automatic queue_op(input logic [1:0] act);
        t_vertex_op op;
        op.action = act;
        op.row    = 2'($urandom_range(3));
        op.col    = 2'($urandom_range(3));
        op.elem   = pick_word(tame_vals);
        for (int k = 0; k < 4; k++) op.vec[k] = pick_word(tame_vals);
        vertex_op_q.push_back(op);
        if (act != ACT_UNUSED) queued_ops++;
    endtask

    task automatic queue_load(input logic [1:0] row, input logic [1:0] col,
                              input logic [31:0] value);
        t_vertex_op op;
        op = '0;
        op.action = ACT_LOAD;
        op.row    = row;
        op.col    = col;
        op.elem   = value;
        op.vec    = {$urandom(), $urandom(), $urandom(), $urandom()};
        vertex_op_q.push_back(op);
        queued_ops++;
    endtask

    task automatic queue_xform(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [31:0] w);
        t_vertex_op op;
        op.action = ACT_XFORM;
        op.row    = 2'($urandom_range(3));
        op.col    = 2'($urandom_range(3));
        op.elem   = $urandom();
        op.vec    = {w, z, y, x};
        vertex_op_q.push_back(op);
        queued_ops++;
    endtask

    task automatic wait_drained();
        while (vertex_op_q.size() != 0 || s_valid) @(negedge i_clk);
    endtask

    // source side: predict on each accepted transfer, then offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            s_user  <= '0;
        end else begin
            if (s_valid && s_ready) apply_vertex_op(held_op);
            if (!s_valid || s_ready) begin
                if (vertex_op_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_op = vertex_op_q.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= IN_DATA_BITS'({held_op.vec, held_op.elem,
                                              held_op.col, held_op.row});
                    s_user  <= held_op.action;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long sink hold-off, counted on its own
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        m_ready <= (hold_left == 0) && !(hold_req && !hold_done) &&
                   ($urandom_range(99) >= recv_stall_pct);
    end

    // sink side: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_xform_result want;
        t_xform_result got;
        string         lane_name [4];
        lane_name = '{"out_x", "out_y", "out_z", "out_w"};
        if (i_rst_n && m_valid && m_ready) begin
            got.lane = m_data;
            got.ovf  = m_user[0];
            n_results++;
            if (got.ovf) n_sat++;
            if (xform_expect_q.size() == 0) begin
                err_cnt++;
                $display("%0t: result with none expected, actual %h ovf %b",
                         $time, m_data, m_user[0]);
            end else begin
                want = xform_expect_q.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got.lane[i] !== want.lane[i]) begin
                        err_cnt++;
                        $display("%0t: %s expected %h actual %h",
                                 $time, lane_name[i], want.lane[i], got.lane[i]);
                    end
                end
                if (got.ovf !== want.ovf) begin
                    err_cnt++;
                    $display("%0t: overflow expected %b actual %b",
                             $time, want.ovf, got.ovf);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("vertex_transform_4x4_top: mismatch");
            $finish;
        end
    end

    initial begin
        int target;
        for (int i = 0; i < 16; i++) mtx_q16[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed: zero matrix, saturating rows, ignored code, inverse corners
        queue_xform(W_MAX, W_MIN, W_MAX, W_MIN);
        for (int c = 0; c < 4; c++) queue_load(2'd0, c[1:0], W_MAX);
        queue_xform(W_MAX, W_MAX, W_MAX, W_MAX);
        queue_xform(W_MIN, W_MIN, W_MIN, W_MIN);
        queue_op(ACT_UNUSED);
        queue_op(ACT_INVERT);
        queue_xform(W_UNIT, W_UNIT, W_UNIT, W_UNIT);
        queue_xform(W_MIN, '0, W_MAX, W_UNIT);
        queue_load(2'd3, 2'd3, W_MIN);
        queue_load(2'd1, 2'd2, 32'hFFFE_8000);
        queue_op(ACT_INVERT);
        queue_xform(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, W_UNIT);
        queue_load(2'd0, 2'd3, W_MIN);
        queue_load(2'd1, 2'd3, W_MAX);
        queue_load(2'd2, 2'd3, 32'h0000_0001);
        queue_op(ACT_INVERT);
        queue_xform(W_UNIT, W_UNIT, W_UNIT, W_UNIT);
        queue_xform(32'hFFFF_FFFF, 32'h0000_0001, W_MIN, W_MAX);
        queue_op(ACT_UNUSED);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            @(negedge i_clk);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            target = queued_ops + PHASE_OPS;
            while (queued_ops < target) begin
                tame_vals = ($urandom_range(2) != 0);
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        // full matrix, then a run of vertices
                        for (int r = 0; r < 4; r++)
                            for (int c = 0; c < 4; c++)
                                queue_load(r[1:0], c[1:0], pick_word(tame_vals));
                        repeat ($urandom_range(20, 4)) queue_op(ACT_XFORM);
                        if ($urandom_range(1)) begin
                            queue_op(ACT_INVERT);
                            repeat ($urandom_range(8, 1)) queue_op(ACT_XFORM);
                        end
                    end
                    4: begin
                        // rigid-style matrix with a proper bottom row
                        for (int r = 0; r < 3; r++)
                            for (int c = 0; c < 4; c++)
                                queue_load(r[1:0], c[1:0], pick_word(1'b1));
                        queue_load(2'd3, 2'd0, '0);
                        queue_load(2'd3, 2'd1, '0);
                        queue_load(2'd3, 2'd2, '0);
                        queue_load(2'd3, 2'd3, W_UNIT);
                        repeat ($urandom_range(6, 1)) queue_op(ACT_XFORM);
                        queue_op(ACT_INVERT);
                        repeat ($urandom_range(6, 1)) queue_op(ACT_XFORM);
                    end
                    5: begin
                        queue_op(ACT_INVERT);
                        repeat ($urandom_range(8, 1)) queue_op(ACT_XFORM);
                    end
                    6, 7: begin
                        repeat ($urandom_range(4, 1)) queue_op(ACT_LOAD);
                        repeat ($urandom_range(6, 1)) queue_op(ACT_XFORM);
                    end
                    8: begin
                        // noise: unused codes mixed with stray work
                        repeat ($urandom_range(3, 1)) queue_op(ACT_UNUSED);
                        queue_op(2'($urandom_range(2)));
                        queue_op(ACT_UNUSED);
                    end
                    default: begin
                        repeat ($urandom_range(40, 10)) queue_op(ACT_XFORM);
                    end
                endcase
            end
            wait_drained();
        end

        while (xform_expect_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("covered %0d loads, %0d transforms (%0d results, %0d saturated), %0d inverses,",
                 n_loads, n_xforms, n_results, n_sat, n_inverts);
        $display("%0d ignored codes; idle phases none/source/sink/both plus one long sink hold",
                 n_ignored);
        if (err_cnt == 0 && xform_expect_q.size() == 0) begin
            $display("vertex_transform_4x4_top: match");
        end else begin
            $display("vertex_transform_4x4_top: mismatch");
        end
        $finish;
    end

endmodule
